// ----- hdl/dspc_pkg.sv -----
// ----------------------------------------------------------------------------
// dspc_pkg
// Shared types and constants of the drivetrain sensor plausibility check.
// ----------------------------------------------------------------------------
package dspc_pkg;

  // field widths
  localparam int SPD_W      = 24;
  localparam int TIME_W     = 32;
  localparam int TRQ_W      = 24;
  localparam int PWR_W      = 32;
  localparam int VLT_W      = 24;
  localparam int CUR_W      = 24;
  localparam int THR_W      = 16;
  localparam int ACC_LIM_W  = 24;
  localparam int ST_W       = 2;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // derived widths
  localparam int SPD_MAG_W = SPD_W;       // magnitude of a signed speed
  localparam int DSPD_W    = SPD_W + 1;   // magnitude of a speed difference
  localparam int DT_W      = TIME_W - 1;  // positive part of a signed time step
  localparam int PWR_MAG_W = PWR_W;

  // rule limits
  localparam logic [SPD_MAG_W-1:0] SPEED_IDLE_LIM = SPD_MAG_W'(100);
  localparam logic [PWR_MAG_W-1:0] MECH_MIN_PWR   = PWR_MAG_W'(1000);
  localparam logic [PWR_MAG_W-1:0] BRAKE_MIN_PWR  = PWR_MAG_W'(100);

  // pi/300 in Q48, split in two halves for the partial products
  localparam int              K_W        = 42;
  localparam int              K_SPLIT    = 21;
  localparam logic [K_W-1:0]  PI_300_Q48 = 42'd2947599063345;

  // job queue between front and back
  localparam int JQ_DEPTH = 2;
  localparam int JQ_PTR_W = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

  // rule status codes
  localparam logic [ST_W-1:0] ST_PASS = 2'd0;
  localparam logic [ST_W-1:0] ST_SKIP = 2'd1;
  localparam logic [ST_W-1:0] ST_FAIL = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SPEED_THR = 2'd0,
    REG_ACCEL_LIM = 2'd1,
    REG_MECH_THR  = 2'd2,
    REG_BRAKE_THR = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [THR_W-1:0]     speed_thr;
    logic [ACC_LIM_W-1:0] accel_lim;
    logic [THR_W-1:0]     mech_thr;
    logic [THR_W-1:0]     brake_thr;
  } cfg_t;

  typedef struct packed {
    logic                     torque_sensor_online;
    logic                     encoder_online;
    logic                     brake_online;
    logic signed [SPD_W-1:0]  sensor_speed;
    logic signed [SPD_W-1:0]  encoder_speed;
    logic [TIME_W-1:0]        sample_time_ms;
    logic signed [TRQ_W-1:0]  shaft_torque;
    logic signed [PWR_W-1:0]  shaft_power;
    logic signed [PWR_W-1:0]  brake_power;
    logic signed [VLT_W-1:0]  brake_voltage;
    logic signed [CUR_W-1:0]  brake_current;
  } in_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                     speed_skip;
    logic                     accel_skip;
    logic                     mech_skip;
    logic                     brake_skip;
    logic [SPD_MAG_W-1:0]     spd_max;
    logic [SPD_MAG_W-1:0]     spd_diff;
    logic [DSPD_W-1:0]        acc_diff;
    logic [DT_W-1:0]          dt;
    logic [TRQ_W-1:0]         torque_mag;
    logic [SPD_MAG_W-1:0]     sens_mag;
    logic                     mech_neg;
    logic signed [PWR_W-1:0]  shaft_power;
    logic [PWR_MAG_W-1:0]     shaft_pm;
    logic signed [PWR_W-1:0]  brake_power;
    logic [PWR_MAG_W-1:0]     brake_pm;
    logic signed [VLT_W-1:0]  brake_voltage;
    logic signed [CUR_W-1:0]  brake_current;
  } job_t;

endpackage

// ----- hdl/dspc_front.sv -----
// ----------------------------------------------------------------------------
// dspc_front
// Classifies each accepted snapshot: magnitudes, skip decisions, time step
// against the stored previous snapshot. Holds the snapshot history.
// ----------------------------------------------------------------------------
module dspc_front import dspc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_item_t item,
  output job_t     job
);

  logic                    prev_valid;
  logic signed [SPD_W-1:0] prev_speed;
  logic [TIME_W-1:0]       prev_time;

  logic [SPD_MAG_W-1:0]    sens_mag;
  logic [SPD_MAG_W-1:0]    enc_mag;
  logic signed [DSPD_W-1:0] spd_delta;
  logic [TIME_W-1:0]       raw_dt;

  function automatic logic [SPD_MAG_W-1:0] mag_spd(input logic signed [SPD_W-1:0] v);
    mag_spd = v[SPD_W-1] ? SPD_MAG_W'(-v) : SPD_MAG_W'(v);
  endfunction

  function automatic logic [PWR_MAG_W-1:0] mag_pwr(input logic signed [PWR_W-1:0] v);
    mag_pwr = v[PWR_W-1] ? PWR_MAG_W'(-v) : PWR_MAG_W'(v);
  endfunction

  always_comb begin
    sens_mag  = mag_spd(item.sensor_speed);
    enc_mag   = mag_spd(item.encoder_speed);
    spd_delta = DSPD_W'(item.encoder_speed) - DSPD_W'(prev_speed);
    raw_dt    = item.sample_time_ms - prev_time;

    job.speed_skip = !item.torque_sensor_online || !item.encoder_online ||
                     (sens_mag < SPEED_IDLE_LIM && enc_mag < SPEED_IDLE_LIM);
    job.spd_max    = (sens_mag > enc_mag) ? sens_mag : enc_mag;
    job.spd_diff   = (sens_mag > enc_mag) ? sens_mag - enc_mag : enc_mag - sens_mag;

    // time step is signed; zero or negative means no usable history
    job.accel_skip = !item.encoder_online || !prev_valid ||
                     raw_dt[TIME_W-1] || (raw_dt == '0);
    job.acc_diff   = spd_delta[DSPD_W-1] ? DSPD_W'(-spd_delta) : DSPD_W'(spd_delta);
    job.dt         = raw_dt[DT_W-1:0];

    job.torque_mag  = mag_spd(item.shaft_torque);
    job.sens_mag    = sens_mag;
    job.mech_neg    = item.shaft_torque[TRQ_W-1] ^ item.sensor_speed[SPD_W-1];
    job.shaft_power = item.shaft_power;
    job.shaft_pm    = mag_pwr(item.shaft_power);
    job.mech_skip   = !item.torque_sensor_online || (job.shaft_pm < MECH_MIN_PWR);

    job.brake_power   = item.brake_power;
    job.brake_pm      = mag_pwr(item.brake_power);
    job.brake_voltage = item.brake_voltage;
    job.brake_current = item.brake_current;
    job.brake_skip    = !item.brake_online || (job.brake_pm < BRAKE_MIN_PWR);
  end

  // every accepted snapshot becomes the previous one, online or not
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      prev_speed <= '0;
      prev_time  <= '0;
    end else if (take) begin
      prev_valid <= item.encoder_online;
      prev_speed <= item.encoder_speed;
      prev_time  <= item.sample_time_ms;
    end
  end

endmodule

// ----- hdl/dspc_job_queue.sv -----
// ----------------------------------------------------------------------------
// dspc_job_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dspc_job_queue import dspc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t                mem [JQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr;
  logic [JQ_PTR_W-1:0] rd_ptr;
  logic [JQ_CNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;

  function automatic logic [JQ_PTR_W-1:0] ptr_inc(input logic [JQ_PTR_W-1:0] p);
    ptr_inc = (p == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == JQ_CNT_W'(JQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= JQ_CNT_W'(JQ_DEPTH))
    else $error("job queue count beyond depth");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> !empty)
    else $error("job queue empty after a push");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == JQ_CNT_W'(1)) |=> empty)
    else $error("job queue not empty after its last item left");
`endif

endmodule

// ----- hdl/dspc_back.sv -----
// ----------------------------------------------------------------------------
// dspc_back
// Evaluates the four rules of one classified item in four steps: products,
// power partial products, power sum, final compare. Holds the result register.
// ----------------------------------------------------------------------------
module dspc_back import dspc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            q_empty,
  input  job_t            q_job,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [ST_W-1:0] speed_status,
  output logic [ST_W-1:0] accel_status,
  output logic [ST_W-1:0] mech_power_status,
  output logic [ST_W-1:0] brake_power_status
);

  localparam int SPD_P_W  = THR_W + SPD_MAG_W;      // speed threshold product
  localparam int ACC_P_W  = ACC_LIM_W + DT_W;       // acceleration limit product
  localparam int TS_W     = TRQ_W + SPD_MAG_W;      // torque times speed
  localparam int TS_HALF  = TS_W / 2;
  localparam int VI_W     = VLT_W + CUR_W;          // voltage times current
  localparam int THR_P_W  = THR_W + PWR_MAG_W;      // power threshold products
  localparam int PP_W     = TS_HALF + K_W - K_SPLIT;
  localparam int SUM_W    = TS_W + K_W;
  localparam int M_W      = SUM_W - 48;             // Q48 result
  localparam int MD_W     = M_W + 2;
  localparam int BD_W     = VI_W + 1;
  localparam int BTHR_W   = THR_P_W + 10;           // threshold times 1000
  localparam int BCMP_W   = BD_W - 1 + 16;
  localparam int MCMP_W   = MD_W + 16;
  localparam int ACC100_W = DSPD_W + 7;

  typedef enum logic [1:0] {IDLE, PART, SUM, CMP} state_e;

  state_e state;

  // latched item fields
  logic                     speed_skip_r, accel_skip_r, mech_skip_r, brake_skip_r;
  logic                     mech_neg_r;
  logic signed [PWR_W-1:0]  shaft_power_r;
  logic signed [PWR_W-1:0]  brake_power_r;
  logic [SPD_MAG_W-1:0]     spd_diff_r;
  logic [DSPD_W-1:0]        acc_diff_r;

  // datapath registers
  logic [SPD_P_W-1:0]       spd_prod;
  logic [ACC_P_W-1:0]       acc_prod;
  logic [TS_W-1:0]          ts_prod;
  logic signed [VI_W-1:0]   vi_prod;
  logic [THR_P_W-1:0]       mthr_prod;
  logic [THR_P_W-1:0]       bthr_prod;
  logic [PP_W-1:0]          pp_ll, pp_lh, pp_hl, pp_hh;
  logic [BD_W-2:0]          bd_mag;
  logic [MD_W-1:0]          md_mag;
  logic [ST_W-1:0]          speed_st, accel_st, brake_st;
  logic                     res_valid;

  // combinational
  logic                     out_free;
  logic                     start;
  logic [SPD_P_W-1:0]       spd_mul;
  logic [ACC_P_W-1:0]       acc_mul;
  logic [TS_W-1:0]          ts_mul;
  logic signed [VI_W-1:0]   vi_mul;
  logic [THR_P_W-1:0]       mthr_mul;
  logic [THR_P_W-1:0]       bthr_mul;
  logic [ACC100_W-1:0]      acc100;
  logic signed [BD_W-1:0]   bp_ext;
  logic signed [BD_W-1:0]   bp1000;
  logic signed [BD_W-1:0]   bdiff;
  logic [BD_W-2:0]          bdiff_mag;
  logic [SUM_W-1:0]         pk_sum;
  logic signed [MD_W-1:0]   m_ext;
  logic signed [MD_W-1:0]   calc;
  logic signed [MD_W-1:0]   mdiff;
  logic [MD_W-1:0]          mdiff_mag;
  logic [BTHR_W-1:0]        bthr1000;
  logic                     speed_pass, accel_pass, brake_pass, mech_pass;

  function automatic logic [ST_W-1:0] rule_st(input logic skip, input logic pass);
    rule_st = skip ? ST_SKIP : (pass ? ST_PASS : ST_FAIL);
  endfunction

  assign out_free = !res_valid || pop;
  assign start    = !q_empty && ((state == IDLE) || (state == CMP && out_free));
  assign q_pop    = start;
  assign empty    = !res_valid;

  always_comb begin
    // products of the first step, straight from the queue head
    spd_mul  = SPD_P_W'(cfg.speed_thr) * SPD_P_W'(q_job.spd_max);
    acc_mul  = ACC_P_W'(cfg.accel_lim) * ACC_P_W'(q_job.dt);
    ts_mul   = TS_W'(q_job.torque_mag) * TS_W'(q_job.sens_mag);
    vi_mul   = VI_W'(q_job.brake_voltage) * VI_W'(q_job.brake_current);
    mthr_mul = THR_P_W'(cfg.mech_thr) * THR_P_W'(q_job.shaft_pm);
    bthr_mul = THR_P_W'(cfg.brake_thr) * THR_P_W'(q_job.brake_pm);

    // speed and acceleration compares
    speed_pass = ({spd_diff_r, 16'b0} <= spd_prod);
    // times 100 = 64 + 32 + 4
    acc100     = {1'b0, acc_diff_r, 6'b0} + {2'b0, acc_diff_r, 5'b0}
                 + {5'b0, acc_diff_r, 2'b0};
    accel_pass = (ACC_P_W'(acc100) <= acc_prod);

    // brake: 1000 * P - V * I, times 1000 = 1024 - 16 - 8
    bp_ext    = BD_W'(brake_power_r);
    bp1000    = (bp_ext <<< 10) - (bp_ext <<< 4) - (bp_ext <<< 3);
    bdiff     = bp1000 - BD_W'(vi_prod);
    bdiff_mag = bdiff[BD_W-1] ? (BD_W-1)'(-bdiff) : (BD_W-1)'(bdiff);
    bthr1000  = {bthr_prod, 10'b0} - {6'b0, bthr_prod, 4'b0} - {7'b0, bthr_prod, 3'b0};
    brake_pass = ({bd_mag, 16'b0} <= BCMP_W'(bthr1000));

    // mechanical power: round half up on the Q48 product
    pk_sum = SUM_W'(pp_ll)
             + (SUM_W'(pp_lh) << K_SPLIT)
             + (SUM_W'(pp_hl) << TS_HALF)
             + (SUM_W'(pp_hh) << (TS_HALF + K_SPLIT))
             + (SUM_W'(1) << 47);
    m_ext     = signed'(MD_W'(pk_sum[SUM_W-1:48]));
    calc      = mech_neg_r ? -m_ext : m_ext;
    mdiff     = MD_W'(shaft_power_r) - calc;
    mdiff_mag = mdiff[MD_W-1] ? MD_W'(-mdiff) : MD_W'(mdiff);
    mech_pass = ({md_mag, 16'b0} <= MCMP_W'(mthr_prod));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
    end else begin
      // in the compare step a pop always frees the slot for the new result
      if (pop && res_valid && state != CMP) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= PART;
          end
        end
        PART: begin
          pp_ll    <= PP_W'(ts_prod[TS_HALF-1:0]) * PP_W'(PI_300_Q48[K_SPLIT-1:0]);
          pp_lh    <= PP_W'(ts_prod[TS_HALF-1:0]) * PP_W'(PI_300_Q48[K_W-1:K_SPLIT]);
          pp_hl    <= PP_W'(ts_prod[TS_W-1:TS_HALF]) * PP_W'(PI_300_Q48[K_SPLIT-1:0]);
          pp_hh    <= PP_W'(ts_prod[TS_W-1:TS_HALF]) * PP_W'(PI_300_Q48[K_W-1:K_SPLIT]);
          speed_st <= rule_st(speed_skip_r, speed_pass);
          accel_st <= rule_st(accel_skip_r, accel_pass);
          bd_mag   <= bdiff_mag;
          state    <= SUM;
        end
        SUM: begin
          md_mag   <= mdiff_mag;
          brake_st <= rule_st(brake_skip_r, brake_pass);
          state    <= CMP;
        end
        CMP: begin
          if (out_free) begin
            res_valid          <= 1'b1;
            speed_status       <= speed_st;
            accel_status       <= accel_st;
            mech_power_status  <= rule_st(mech_skip_r, mech_pass);
            brake_power_status <= brake_st;
            state              <= start ? PART : IDLE;
          end
        end
      endcase
      // first step of the next item
      if (start) begin
        spd_prod      <= spd_mul;
        acc_prod      <= acc_mul;
        ts_prod       <= ts_mul;
        vi_prod       <= vi_mul;
        mthr_prod     <= mthr_mul;
        bthr_prod     <= bthr_mul;
        speed_skip_r  <= q_job.speed_skip;
        accel_skip_r  <= q_job.accel_skip;
        mech_skip_r   <= q_job.mech_skip;
        brake_skip_r  <= q_job.brake_skip;
        mech_neg_r    <= q_job.mech_neg;
        shaft_power_r <= q_job.shaft_power;
        brake_power_r <= q_job.brake_power;
        spd_diff_r    <= q_job.spd_diff;
        acc_diff_r    <= q_job.acc_diff;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == IDLE || state == CMP))
    else $error("job taken while an item is in flight");

  a_part_to_sum: assert property (@(posedge clk) disable iff (rst)
    state == PART |=> state == SUM)
    else $error("partial product step not followed by sum");

  a_sum_to_cmp: assert property (@(posedge clk) disable iff (rst)
    state == SUM |=> state == CMP)
    else $error("sum step not followed by compare");

  a_result_from_cmp: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == CMP)
    else $error("result appeared outside the compare step");
`endif

endmodule

// ----- hdl/drivetrain_sensor_plausibility_check.sv -----
// ----------------------------------------------------------------------------
// drivetrain_sensor_plausibility_check
// Four plausibility rules on each telemetry snapshot; one status per rule.
//
//   channel   handshake              payload
//   input     push / full            snapshot fields
//   result    empty / pop            four rule statuses
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes one item per cycle, while the queue has room, into a
// two-entry job queue. The back spends four steps on each item (products,
// power partial products, power sum, compare); the compare step overlaps
// the next item's products, so back to back the back starts the next item
// while it finishes the last one.
// An unread result stalls the back in its compare step; the queue keeps
// the input open until it fills. Reset is synchronous, with no clearing
// pass; config writes are picked up when the back starts an item.
// ----------------------------------------------------------------------------
module drivetrain_sensor_plausibility_check import dspc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // input items
  input  logic                    push,
  output logic                    full,
  input  logic                    torque_sensor_online,
  input  logic                    encoder_online,
  input  logic                    brake_online,
  input  logic signed [SPD_W-1:0] sensor_speed,
  input  logic signed [SPD_W-1:0] encoder_speed,
  input  logic [TIME_W-1:0]       sample_time_ms,
  input  logic signed [TRQ_W-1:0] shaft_torque,
  input  logic signed [PWR_W-1:0] shaft_power,
  input  logic signed [PWR_W-1:0] brake_power,
  input  logic signed [VLT_W-1:0] brake_voltage,
  input  logic signed [CUR_W-1:0] brake_current,
  // results
  output logic                    empty,
  input  logic                    pop,
  output logic [ST_W-1:0]         speed_status,
  output logic [ST_W-1:0]         accel_status,
  output logic [ST_W-1:0]         mech_power_status,
  output logic [ST_W-1:0]         brake_power_status,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t     cfg;
  in_item_t item;
  job_t     front_job;
  job_t     q_job;
  logic     take;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_thr <= THR_W'(3277);
      cfg.accel_lim <= ACC_LIM_W'(5000);
      cfg.mech_thr  <= THR_W'(6554);
      cfg.brake_thr <= THR_W'(6554);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SPEED_THR: cfg.speed_thr <= cfg_data[THR_W-1:0];
        REG_ACCEL_LIM: cfg.accel_lim <= cfg_data[ACC_LIM_W-1:0];
        REG_MECH_THR:  cfg.mech_thr  <= cfg_data[THR_W-1:0];
        REG_BRAKE_THR: cfg.brake_thr <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    item.torque_sensor_online = torque_sensor_online;
    item.encoder_online       = encoder_online;
    item.brake_online         = brake_online;
    item.sensor_speed         = sensor_speed;
    item.encoder_speed        = encoder_speed;
    item.sample_time_ms       = sample_time_ms;
    item.shaft_torque         = shaft_torque;
    item.shaft_power          = shaft_power;
    item.brake_power          = brake_power;
    item.brake_voltage        = brake_voltage;
    item.brake_current        = brake_current;
  end

  assign full = q_full;
  assign take = push && !q_full;

  dspc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .job  (front_job)
  );

  dspc_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  dspc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_job              (q_job),
    .q_pop              (q_pop),
    .pop                (pop),
    .empty              (empty),
    .speed_status       (speed_status),
    .accel_status       (accel_status),
    .mech_power_status  (mech_power_status),
    .brake_power_status (brake_power_status)
  );

endmodule
